/* sv/prs_pkg.sv */
// Shared types and constants of the persistent RPN stack.
package prs_pkg;
    localparam int NodeCountDef    = 1024;
    localparam int HistoryDepthDef = 1024;
    localparam int FracBitsDef     = 32;
    localparam int ValW            = 64;

    typedef enum logic [2:0] {
        REQ_PUSH = 3'd0, REQ_ADD = 3'd1, REQ_SUB = 3'd2, REQ_MUL = 3'd3,
        REQ_DIV  = 3'd4, REQ_DROP = 3'd5, REQ_SWAP = 3'd6, REQ_UNDO = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNDERFLOW = 2'd1, ST_NO_UNDO = 2'd2, ST_FULL = 2'd3
    } t_status;

    localparam logic [ValW-1:0] PosMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic [ValW-1:0] NegMax = {1'b1, {(ValW-1){1'b0}}};

    typedef struct packed {
        logic           start;
        logic [2:0]     op;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic           done;
        logic [ValW-1:0] res;
    } t_alu_rsp;
endpackage

/* sv/prs_alu.sv */
// Saturating fixed-point ALU: add, subtract, multiply in 4 partial products, serial divide.
module prs_alu #(
    parameter int FRAC_BITS = prs_pkg::FracBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prs_pkg::t_alu_req i_req,
    output prs_pkg::t_alu_rsp o_rsp
);
    import prs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MULSUM, S_DIV, S_FIN} t_st;

    t_st              r_st;
    logic [2:0]       r_op;
    logic             r_neg;
    logic [63:0]      r_x, r_y;
    logic [127:0]     r_acc;
    logic [1:0]       r_pp;
    logic [127:0]     r_num;
    logic [63:0]      r_rem;
    logic [6:0]       r_cnt;
    logic [63:0]      r_res;
    logic             r_done;
    logic [63:0]      r_a, r_b;

    logic [63:0] mag_a, mag_b, sum, dif, sat_q;
    logic [31:0] px, py;
    logic [63:0] pprod;
    logic [127:0] pshift, mprod;
    logic        carry;
    logic [63:0] rsh;
    logic [127:0] qv;

    assign mag_a = i_req.a[63] ? 64'(0 - i_req.a) : i_req.a;
    assign mag_b = i_req.b[63] ? 64'(0 - i_req.b) : i_req.b;
    assign sum = r_a + r_b;
    assign dif = r_a - r_b;
    assign px = r_pp[0] ? r_x[63:32] : r_x[31:0];
    assign py = r_pp[1] ? r_y[63:32] : r_y[31:0];
    assign pprod = 64'(px) * 64'(py);
    assign pshift = 128'(pprod) << (32 * (32'(r_pp[0]) + 32'(r_pp[1])));
    assign mprod = r_acc >> FRAC_BITS;
    assign carry = r_rem[63];
    assign rsh = {r_rem[62:0], r_num[127]};
    assign qv = (r_op == REQ_MUL) ? mprod : r_num;

    always_comb begin
        if (r_neg) begin
            sat_q = (qv[127:64] != 0 || qv[63:0] > NegMax) ? NegMax : 64'(0 - qv[63:0]);
        end else begin
            sat_q = (qv[127:64] != 0 || qv[63:0] > PosMax) ? PosMax : qv[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_a   <= i_req.a;
                        r_b   <= i_req.b;
                        r_neg <= i_req.a[63] ^ i_req.b[63];
                        r_x   <= mag_a;
                        r_y   <= mag_b;
                        r_acc <= '0;
                        r_pp  <= 2'd0;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_num <= 128'(mag_a) << FRAC_BITS;
                        if (i_req.op == REQ_MUL) r_st <= S_MUL;
                        else if (i_req.op == REQ_DIV) r_st <= S_DIV;
                        else r_st <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + pshift;
                    r_pp  <= r_pp + 2'd1;
                    if (r_pp == 2'd3) r_st <= S_MULSUM;
                end
                S_MULSUM: begin
                    r_res  <= sat_q;
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                S_DIV: begin
                    if (r_y == 0) begin
                        r_res  <= (r_a == 0) ? 64'd0 : (r_a[63] ? NegMax : PosMax);
                        r_done <= 1'b1;
                        r_st   <= S_IDLE;
                    end else begin
                        if (carry || rsh >= r_y) begin
                            r_rem <= rsh - r_y;
                            r_num <= {r_num[126:0], 1'b1};
                        end else begin
                            r_rem <= rsh;
                            r_num <= {r_num[126:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd127) r_st <= S_MULSUM;
                    end
                end
                S_FIN: begin
                    if (r_op == REQ_ADD) begin
                        r_res <= (!(r_a[63] ^ r_b[63]) && (sum[63] ^ r_a[63]))
                               ? (r_a[63] ? NegMax : PosMax) : sum;
                    end else begin
                        r_res <= ((r_a[63] ^ r_b[63]) && (dif[63] ^ r_a[63]))
                               ? (r_a[63] ? NegMax : PosMax) : dif;
                    end
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

/* sv/persistent_rpn_stack_with_undo.sv */
// Top level of the persistent RPN stack calculator with undo.
// Channels: slave stream takes one request per transaction,
//   s_axis_tuser = req_type[2:0], s_axis_tdata = push_value[63:0].
// Master stream gives one result per request,
//   m_axis_tuser = {status[2:1], shown[0]}, m_axis_tdata = shown_value[63:0].
// Requests are handled one at a time. The node pool and the version history
// sit in synchronous RAMs with registered reads; an item walks history head,
// head node and second node reads, then writes new nodes and a version.
// Divide uses the 128-step serial divider of the ALU; the block returns to
// idle before the next request is taken.
// A result waits in the output register; the next request is accepted
// while it waits, and a further result stalls until it is taken.
// Reset (synchronous, active low) empties history and pool by clearing the
// counters; memory contents are never cleared since unwritten entries are
// never read.
module persistent_rpn_stack_with_undo #(
    parameter int NODE_COUNT    = prs_pkg::NodeCountDef,
    parameter int HISTORY_DEPTH = prs_pkg::HistoryDepthDef,
    parameter int FRAC_BITS     = prs_pkg::FracBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // push_value[63:0]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // shown_value[63:0]
    output logic [2:0]  m_axis_tuser   // shown[0], status[2:1]
);
    import prs_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RDH, S_HWAIT, S_RD1, S_RD2, S_RD2W, S_DEC,
        S_ALU, S_W1, S_W2, S_UNDO, S_OUT
    } t_st;

    logic [63:0]   m_val  [NODE_COUNT];
    logic [LW-1:0] m_link [NODE_COUNT];
    logic [LW-1:0] m_hist [HISTORY_DEPTH];

    t_st           r_st;
    logic [2:0]    r_req;
    logic [63:0]   r_pv;
    logic [CW-1:0] r_vc;
    logic [LW-1:0] r_free;
    logic [LW-1:0] r_head, r_sec, r_rest;
    logic [63:0]   r_top, r_secv;
    logic [63:0]   r_rdv;
    logic [LW-1:0] r_rdl, r_rdh;
    logic          r_ovalid;
    logic [63:0]   r_oval;
    logic [2:0]    r_ouser;
    logic          r_shown;
    logic [63:0]   r_val;
    logic [1:0]    r_status;
    logic          r_aluw;

    logic          nd_we, hs_we;
    logic [NW-1:0] nd_wa, nd_ra;
    logic [63:0]   nd_wv;
    logic [LW-1:0] nd_wl;
    logic [HW-1:0] hs_wa, hs_ra;
    logic [LW-1:0] hs_wd;
    logic          hist_full;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic [LW:0]   free_need;

    assign hist_full = r_vc >= CW'(HISTORY_DEPTH);
    assign free_need = (LW+1)'(r_free) + ((r_req == REQ_SWAP) ? (LW+1)'(2) : (LW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            m_val[nd_wa]  <= nd_wv;
            m_link[nd_wa] <= nd_wl;
        end
        r_rdv <= m_val[nd_ra];
        r_rdl <= m_link[nd_ra];
        if (hs_we) m_hist[hs_wa] <= hs_wd;
        r_rdh <= m_hist[hs_ra];
    end

    always_comb begin
        nd_we = 1'b0; nd_wa = r_free[NW-1:0]; nd_wv = r_pv; nd_wl = r_head;
        hs_we = 1'b0; hs_wa = r_vc[HW-1:0]; hs_wd = LW'(r_free) + LW'(1);
        nd_ra = '0; hs_ra = '0;
        case (r_st)
            S_RDH:  hs_ra = HW'(r_vc - CW'(1));
            S_UNDO: hs_ra = HW'(r_vc - CW'(1));
            S_RD1:  nd_ra = NW'(r_head - LW'(1));
            S_RD2:  nd_ra = NW'(r_rdl - LW'(1));
            S_W1: begin
                nd_we = 1'b1;
                hs_we = (r_req != REQ_SWAP);
                if (r_req == REQ_SWAP) begin
                    nd_wv = r_top; nd_wl = r_rest;
                end else if (r_req == REQ_PUSH) begin
                    nd_wv = r_pv; nd_wl = r_head;
                end else begin
                    nd_wv = r_val; nd_wl = r_rest;
                end
            end
            S_W2: begin
                // swap adds its second node; drop and underflow only record a version
                hs_we = 1'b1;
                nd_wv = r_secv; nd_wl = r_free;
                if (r_req == REQ_SWAP && r_status == ST_OK) begin
                    nd_we = 1'b1;
                end else begin
                    hs_wd = (r_req == REQ_DROP) ? r_sec : '0;
                end
            end
            default: ;
        endcase
    end

    assign alu_req.start = (r_st == S_ALU) && !r_aluw;
    assign alu_req.op = r_req;
    assign alu_req.a  = r_secv;
    assign alu_req.b  = r_top;

    prs_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk (i_clk), .i_rst_n(i_rst_n), .i_req(alu_req), .o_rsp(alu_rsp)
    );

    assign s_axis_tready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_vc <= '0; r_free <= '0;
            r_ovalid <= 1'b0; r_aluw <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req <= s_axis_tuser; r_pv <= s_axis_tdata;
                        r_shown <= 1'b0; r_val <= '0; r_status <= ST_OK;
                        r_head <= '0;
                        if (s_axis_tuser == REQ_UNDO) r_st <= S_DEC;
                        else r_st <= (r_vc != 0) ? S_RDH : S_RD1;
                    end
                end
                S_RDH:  r_st <= S_HWAIT;
                S_HWAIT: begin
                    r_head <= r_rdh; r_st <= S_RD1;
                end
                S_RD1: begin
                    r_sec <= '0;
                    r_st <= (r_head != 0) ? S_RD2 : S_DEC;
                end
                S_RD2: begin
                    r_top <= r_rdv; r_sec <= r_rdl;
                    r_st <= (r_rdl != 0) ? S_RD2W : S_DEC;
                end
                S_RD2W: begin
                    r_secv <= r_rdv; r_rest <= r_rdl; r_st <= S_DEC;
                end
                S_DEC: begin
                    r_st <= S_OUT;
                    case (r_req)
                        REQ_PUSH: begin
                            if (hist_full || r_free >= LW'(NODE_COUNT)) r_status <= ST_FULL;
                            else begin
                                r_shown <= 1'b1; r_val <= r_pv; r_st <= S_W1;
                            end
                        end
                        REQ_DROP: begin
                            if (r_head == 0) r_status <= ST_UNDERFLOW;
                            else if (hist_full) r_status <= ST_FULL;
                            else begin
                                if (r_sec != 0) begin
                                    r_shown <= 1'b1; r_val <= r_secv;
                                end
                                r_st <= S_W2;
                            end
                        end
                        REQ_UNDO: begin
                            if (r_vc == 0) r_status <= ST_NO_UNDO;
                            else begin
                                r_vc <= r_vc - CW'(1);
                                if (r_vc > CW'(1)) r_st <= S_UNDO;
                            end
                        end
                        default: begin
                            if (r_head == 0 || r_sec == 0) begin
                                if (hist_full) r_status <= ST_FULL;
                                else begin
                                    r_status <= ST_UNDERFLOW; r_st <= S_W2;
                                end
                            end else if (hist_full || free_need > (LW+1)'(NODE_COUNT))
                                r_status <= ST_FULL;
                            else begin
                                r_shown <= 1'b1;
                                if (r_req == REQ_SWAP) begin
                                    r_val <= r_secv; r_st <= S_W1;
                                end else r_st <= S_ALU;
                            end
                        end
                    endcase
                end
                S_ALU: begin
                    r_aluw <= 1'b1;
                    if (alu_rsp.done) begin
                        r_val <= alu_rsp.res; r_aluw <= 1'b0; r_st <= S_W1;
                    end
                end
                S_W1: begin
                    r_free <= r_free + LW'(1);
                    if (r_req == REQ_SWAP) r_st <= S_W2;
                    else begin
                        r_vc <= r_vc + CW'(1); r_st <= S_OUT;
                    end
                end
                S_W2: begin
                    r_vc <= r_vc + CW'(1);
                    if (r_req == REQ_SWAP && r_status == ST_OK) r_free <= r_free + LW'(1);
                    r_st <= S_OUT;
                end
                S_UNDO: r_st <= S_HWAIT;
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oval <= r_shown ? r_val : 64'd0;
                        r_ouser <= {r_status, r_shown};
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_HWAIT && r_req == REQ_UNDO) begin
                r_st <= (r_rdh != 0) ? S_RD1 : S_OUT;
            end
            if (r_st == S_RD1 && r_req == REQ_UNDO && r_head != 0) r_st <= S_RD2;
            if (r_st == S_RD2 && r_req == REQ_UNDO) begin
                r_shown <= 1'b1; r_val <= r_rdv; r_st <= S_OUT;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_ouser;
endmodule

/* sv/prs_checker.sv */
// Port-level checks of the persistent RPN stack, bound to the top level.
module prs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("value without shown flag");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind persistent_rpn_stack_with_undo prs_checker u_prs_checker (.*);
